// ===== hw/rtl/rsr_pkg.sv =====
package rsr_pkg;

    // histogram geometry
    localparam int MAX_LABELS = 1024;
    localparam int ADDR_W     = $clog2(MAX_LABELS);
    localparam int LABEL_W    = 10;
    localparam int COUNT_W    = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // ranking limits
    localparam int MAX_EMIT = 64;
    localparam int RANK_W   = 6;
    localparam int TOP_W    = 7;
    localparam logic [TOP_W-1:0] TOP_COUNT_RESET = TOP_W'(50);

    // queue sizes
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // item class decided at the front
    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_VOXEL,
        KIND_FINISH
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [LABEL_W-1:0] label;
    } item_t;

    // front queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        item_t item;
    } front_out_t;

    // back part control toward the front
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctl_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [LABEL_W-1:0] region_label;
        logic [COUNT_W-1:0] voxel_count;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_RUN,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } back_state_t;

endpackage

// ===== hw/rtl/region_size_ranker.sv =====
// voxels: counted via the front queue and the s1 stage; one label per cycle while in ST_RUN
// finish: min(top_count, 64, largest) passes over labels 1..largest, each on the single
//   read port of the count memory, then the counts of labels 0..largest are zeroed
// throughput: one result per pass; the result queue holds two results
// reset: asynchronous, active low; afterwards all 1024 entries of the count memory are zeroed
//   with full held high, top_count returns to 50
module region_size_ranker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         op,
    input  logic [rsr_pkg::LABEL_W-1:0]  label,
    output logic                         empty,
    input  logic                         pop,
    output logic [rsr_pkg::RANK_W-1:0]   rank,
    output logic [rsr_pkg::LABEL_W-1:0]  region_label,
    output logic [rsr_pkg::COUNT_W-1:0]  voxel_count,
    output logic                         last,
    input  logic                         cfg_write,
    input  logic [rsr_pkg::TOP_W-1:0]    cfg_data
);

    logic [rsr_pkg::TOP_W-1:0] top_count_reg;
    rsr_pkg::back_ctl_t        ctl;
    rsr_pkg::front_out_t       head;
    logic                      res_push;
    rsr_pkg::result_t          res_data;
    logic                      res_full;
    rsr_pkg::result_t          out_data;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= rsr_pkg::TOP_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            top_count_reg <= cfg_data;
        end
    end

    // item queue with classification
    rsr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .op    (op),
        .label (label),
        .full  (full),
        .ctl   (ctl),
        .head  (head)
    );

    // histogram and ranking engine
    rsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .top_count (top_count_reg),
        .head      (head),
        .ctl       (ctl),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // result queue
    rsr_out_queue u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .q_full  (res_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (out_data)
    );

    assign rank         = out_data.rank;
    assign region_label = out_data.region_label;
    assign voxel_count  = out_data.voxel_count;
    assign last         = out_data.last;

endmodule

// ===== hw/rtl/rsr_ram.sv =====
module rsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rsr_front.sv =====
module rsr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         op,
    input  logic [rsr_pkg::LABEL_W-1:0]  label,
    output logic                         full,
    input  rsr_pkg::back_ctl_t           ctl,
    output rsr_pkg::front_out_t          head
);

    rsr_pkg::item_t                mem_reg [rsr_pkg::FQ_DEPTH];
    logic [rsr_pkg::FQ_PTR_W-1:0]  wr_ptr_reg;
    logic [rsr_pkg::FQ_PTR_W-1:0]  rd_ptr_reg;
    logic [rsr_pkg::FQ_PTR_W:0]    cnt_reg;
    rsr_pkg::item_t                item_in;
    logic                          do_push;
    logic                          do_pop;

    // classify the incoming item
    always_comb
    begin
        item_in.label = label;
        if (op)
        begin
            item_in.kind = rsr_pkg::KIND_FINISH;
        end
        else if ((label != '0) && (int'(label) < rsr_pkg::MAX_LABELS))
        begin
            item_in.kind = rsr_pkg::KIND_VOXEL;
        end
        else
        begin
            item_in.kind = rsr_pkg::KIND_SKIP;
        end
    end

    // no transfer while the back part sweeps the histogram after reset
    assign full    = (cnt_reg == (rsr_pkg::FQ_PTR_W + 1)'(rsr_pkg::FQ_DEPTH)) || ctl.init_busy;
    assign do_push = push && !full;
    assign do_pop  = ctl.pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rsr_out_queue.sv =====
module rsr_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rsr_pkg::result_t   wr_data,
    output logic               q_full,
    input  logic               pop,
    output logic               empty,
    output rsr_pkg::result_t   rd_data
);

    rsr_pkg::result_t              mem_reg [rsr_pkg::OQ_DEPTH];
    logic [rsr_pkg::OQ_PTR_W-1:0]  wr_ptr_reg;
    logic [rsr_pkg::OQ_PTR_W-1:0]  rd_ptr_reg;
    logic [rsr_pkg::OQ_PTR_W:0]    cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    assign q_full  = (cnt_reg == (rsr_pkg::OQ_PTR_W + 1)'(rsr_pkg::OQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = wr_en && !q_full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // result storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // result pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rsr_back.sv =====
module rsr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rsr_pkg::TOP_W-1:0]   top_count,
    input  rsr_pkg::front_out_t         head,
    output rsr_pkg::back_ctl_t          ctl,
    output logic                        res_push,
    output rsr_pkg::result_t            res_data,
    input  logic                        res_full
);

    rsr_pkg::back_state_t          state_reg, state_next;

    // histogram increment stage and write bypass
    logic                          s1_valid_reg, s1_valid_next;
    logic [rsr_pkg::ADDR_W-1:0]    s1_addr_reg, s1_addr_next;
    logic                          lw_valid_reg, lw_valid_next;
    logic [rsr_pkg::ADDR_W-1:0]    lw_addr_reg, lw_addr_next;
    logic [rsr_pkg::COUNT_W-1:0]   lw_data_reg, lw_data_next;
    logic [rsr_pkg::LABEL_W-1:0]   largest_reg, largest_next;

    // ranking state
    logic [rsr_pkg::TOP_W-1:0]     n_reg, n_next;
    logic [rsr_pkg::TOP_W-1:0]     rank_reg, rank_next;
    logic [rsr_pkg::LABEL_W-1:0]   issue_reg, issue_next;
    logic                          issuing_reg, issuing_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [rsr_pkg::LABEL_W-1:0]   chk_label_reg, chk_label_next;
    logic                          found_reg, found_next;
    logic                          first_reg, first_next;
    logic [rsr_pkg::LABEL_W-1:0]   best_label_reg, best_label_next;
    logic [rsr_pkg::COUNT_W-1:0]   best_count_reg, best_count_next;
    logic [rsr_pkg::LABEL_W-1:0]   prev_label_reg, prev_label_next;
    logic [rsr_pkg::COUNT_W-1:0]   prev_count_reg, prev_count_next;
    logic [rsr_pkg::ADDR_W-1:0]    clr_reg, clr_next;

    // memory port
    logic                          ram_we;
    logic [rsr_pkg::ADDR_W-1:0]    ram_waddr;
    logic [rsr_pkg::COUNT_W-1:0]   ram_wdata;
    logic [rsr_pkg::ADDR_W-1:0]    ram_raddr;
    logic [rsr_pkg::COUNT_W-1:0]   ram_rdata;

    // datapath temporaries
    logic [rsr_pkg::COUNT_W-1:0]   cur_count;
    logic [rsr_pkg::COUNT_W-1:0]   inc_count;
    logic [rsr_pkg::TOP_W-1:0]     limit;
    logic [rsr_pkg::TOP_W-1:0]     n_calc;
    logic                          eligible;
    logic                          is_last;
    logic                          head_pop;

    rsr_ram #(
        .WIDTH (rsr_pkg::COUNT_W),
        .DEPTH (rsr_pkg::MAX_LABELS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // saturating increment with bypass of the previous cycle's write
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == s1_addr_reg))
        begin
            cur_count = lw_data_reg;
        end
        else
        begin
            cur_count = ram_rdata;
        end
        if (cur_count == rsr_pkg::COUNT_MAX)
        begin
            inc_count = cur_count;
        end
        else
        begin
            inc_count = cur_count + 1'b1;
        end
    end

    // number of results for this finish
    always_comb
    begin
        if (int'(top_count) > rsr_pkg::MAX_EMIT)
        begin
            limit = rsr_pkg::TOP_W'(rsr_pkg::MAX_EMIT);
        end
        else
        begin
            limit = top_count;
        end
        if (largest_reg > rsr_pkg::LABEL_W'(limit))
        begin
            n_calc = limit;
        end
        else
        begin
            n_calc = rsr_pkg::TOP_W'(largest_reg);
        end
    end

    // a label is a candidate if it ranks strictly after the previous pick
    assign eligible = first_reg
                   || (ram_rdata < prev_count_reg)
                   || ((ram_rdata == prev_count_reg) && (chk_label_reg > prev_label_reg));
    assign is_last  = ((rank_reg + 1'b1) == n_reg);

    // result fields
    assign res_data.rank         = rank_reg[rsr_pkg::RANK_W-1:0];
    assign res_data.region_label = best_label_reg;
    assign res_data.voxel_count  = best_count_reg;
    assign res_data.last         = is_last;

    assign ctl.init_busy = (state_reg == rsr_pkg::ST_INIT);
    assign ctl.pop       = head_pop;

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        s1_valid_next   = 1'b0;
        s1_addr_next    = s1_addr_reg;
        lw_valid_next   = 1'b0;
        lw_addr_next    = lw_addr_reg;
        lw_data_next    = lw_data_reg;
        largest_next    = largest_reg;
        n_next          = n_reg;
        rank_next       = rank_reg;
        issue_next      = issue_reg;
        issuing_next    = issuing_reg;
        chk_valid_next  = 1'b0;
        chk_label_next  = chk_label_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        best_label_next = best_label_reg;
        best_count_next = best_count_reg;
        prev_label_next = prev_label_reg;
        prev_count_next = prev_count_reg;
        clr_next        = clr_reg;
        head_pop        = 1'b0;
        res_push        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = clr_reg;
        ram_wdata       = '0;
        ram_raddr       = rsr_pkg::ADDR_W'(head.item.label);

        // write back the counted voxel
        if (s1_valid_reg)
        begin
            ram_we        = 1'b1;
            ram_waddr     = s1_addr_reg;
            ram_wdata     = inc_count;
            lw_valid_next = 1'b1;
            lw_addr_next  = s1_addr_reg;
            lw_data_next  = inc_count;
        end

        case (state_reg)
            rsr_pkg::ST_INIT:
            begin
                // zero every entry after reset
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == rsr_pkg::ADDR_W'(rsr_pkg::MAX_LABELS - 1))
                begin
                    clr_next   = '0;
                    state_next = rsr_pkg::ST_RUN;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            rsr_pkg::ST_RUN:
            begin
                if (head.valid)
                begin
                    case (head.item.kind)
                        rsr_pkg::KIND_VOXEL:
                        begin
                            head_pop      = 1'b1;
                            s1_valid_next = 1'b1;
                            s1_addr_next  = rsr_pkg::ADDR_W'(head.item.label);
                            if (head.item.label > largest_reg)
                            begin
                                largest_next = head.item.label;
                            end
                        end
                        rsr_pkg::KIND_FINISH:
                        begin
                            // wait for the last increment to land
                            if (!s1_valid_reg)
                            begin
                                head_pop     = 1'b1;
                                n_next       = n_calc;
                                rank_next    = '0;
                                first_next   = 1'b1;
                                found_next   = 1'b0;
                                issue_next   = rsr_pkg::LABEL_W'(1);
                                issuing_next = 1'b1;
                                clr_next     = '0;
                                if (n_calc == '0)
                                begin
                                    state_next = rsr_pkg::ST_CLEAR;
                                end
                                else
                                begin
                                    state_next = rsr_pkg::ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            head_pop = 1'b1;
                        end
                    endcase
                end
            end

            rsr_pkg::ST_SCAN:
            begin
                // issue reads of labels 1..largest
                ram_raddr = rsr_pkg::ADDR_W'(issue_reg);
                if (issuing_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_label_next = issue_reg;
                    if (issue_reg == largest_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
                // keep the first candidate with the highest count
                if (chk_valid_reg)
                begin
                    if (eligible && (!found_reg || (ram_rdata > best_count_reg)))
                    begin
                        found_next      = 1'b1;
                        best_label_next = chk_label_reg;
                        best_count_next = ram_rdata;
                    end
                    if (chk_label_reg == largest_reg)
                    begin
                        state_next = rsr_pkg::ST_EMIT;
                    end
                end
            end

            rsr_pkg::ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    prev_label_next = best_label_reg;
                    prev_count_next = best_count_reg;
                    if (is_last)
                    begin
                        clr_next   = '0;
                        state_next = rsr_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        rank_next    = rank_reg + 1'b1;
                        first_next   = 1'b0;
                        found_next   = 1'b0;
                        issue_next   = rsr_pkg::LABEL_W'(1);
                        issuing_next = 1'b1;
                        state_next   = rsr_pkg::ST_SCAN;
                    end
                end
            end

            rsr_pkg::ST_CLEAR:
            begin
                // zero the entries that can be nonzero
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == rsr_pkg::ADDR_W'(largest_reg))
                begin
                    clr_next     = '0;
                    largest_next = '0;
                    state_next   = rsr_pkg::ST_RUN;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            default:
            begin
                clr_next   = '0;
                state_next = rsr_pkg::ST_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsr_pkg::ST_INIT;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            largest_reg   <= '0;
            n_reg         <= '0;
            rank_reg      <= '0;
            issue_reg     <= '0;
            issuing_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            lw_valid_reg  <= lw_valid_next;
            largest_reg   <= largest_next;
            n_reg         <= n_next;
            rank_reg      <= rank_next;
            issue_reg     <= issue_next;
            issuing_reg   <= issuing_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            clr_reg       <= clr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_addr_reg    <= s1_addr_next;
        lw_addr_reg    <= lw_addr_next;
        lw_data_reg    <= lw_data_next;
        chk_label_reg  <= chk_label_next;
        best_label_reg <= best_label_next;
        best_count_reg <= best_count_next;
        prev_label_reg <= prev_label_next;
        prev_count_reg <= prev_count_next;
    end

endmodule

// ===== tb/region_size_ranker_test.sv =====
module region_size_ranker_test;

    // item codes on the op input
    localparam logic OP_VOXEL  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // quiet cycles before a register write or the end: covers the count clearing pass
    localparam int SETTLE_CYCLES = 1100;
    // length of the long result stall
    localparam int HOLD_CYCLES   = 400;
    // percent of cycles each side idles
    localparam int IDLE_PCT      = 23;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          push      = 1'b0;
    logic                          op        = 1'b0;
    logic [rsr_pkg::LABEL_W-1:0]   label     = '0;
    logic                          pop       = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [rsr_pkg::TOP_W-1:0]     cfg_data  = '0;
    logic                          full;
    logic                          empty;
    logic [rsr_pkg::RANK_W-1:0]    rank;
    logic [rsr_pkg::LABEL_W-1:0]   region_label;
    logic [rsr_pkg::COUNT_W-1:0]   voxel_count;
    logic                          last;

    // histogram mirror and ranking expectations
    logic [rsr_pkg::COUNT_W-1:0]   label_hist [rsr_pkg::MAX_LABELS];
    logic [rsr_pkg::LABEL_W-1:0]   top_label;
    logic [rsr_pkg::TOP_W-1:0]     emit_limit;
    rsr_pkg::result_t              ranked_q [$];

    bit                            failed    = 1'b0;
    bit                            steady    = 1'b0;
    bit                            hold_req  = 1'b0;
    int                            hold_left = 0;
    int                            items_sent = 0;

    region_size_ranker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .label        (label),
        .empty        (empty),
        .pop          (pop),
        .rank         (rank),
        .region_label (region_label),
        .voxel_count  (voxel_count),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // update the histogram mirror for one accepted item; a finish ranks and clears
    function automatic void apply_item(logic op_code, logic [rsr_pkg::LABEL_W-1:0] lab);
        bit                          picked [rsr_pkg::MAX_LABELS];
        rsr_pkg::result_t            res;
        int                          limit;
        int                          n;
        int                          r;
        int                          l;
        int                          best;
        logic [rsr_pkg::COUNT_W-1:0] best_count;
        bit                          found;
        if (op_code == OP_VOXEL)
        begin
            // background voxels are not counted
            if (lab != '0)
            begin
                if (label_hist[lab] != rsr_pkg::COUNT_MAX)
                    label_hist[lab] = label_hist[lab] + 1'b1;
                if (lab > top_label)
                    top_label = lab;
            end
        end
        else
        begin
            limit = (emit_limit > rsr_pkg::MAX_EMIT) ? rsr_pkg::MAX_EMIT : int'(emit_limit);
            n = (int'(top_label) < limit) ? int'(top_label) : limit;
            for (l = 0; l < rsr_pkg::MAX_LABELS; l++)
                picked[l] = 1'b0;
            // selection by highest count, first label wins on ties
            for (r = 0; r < n; r++)
            begin
                best = 0;
                best_count = '0;
                found = 1'b0;
                for (l = 1; l <= int'(top_label); l++)
                begin
                    if (!picked[l] && (!found || label_hist[l] > best_count))
                    begin
                        best = l;
                        best_count = label_hist[l];
                        found = 1'b1;
                    end
                end
                picked[best] = 1'b1;
                res.rank = rsr_pkg::RANK_W'(r);
                res.region_label = rsr_pkg::LABEL_W'(best);
                res.voxel_count = best_count;
                res.last = (r + 1 == n);
                ranked_q.insert(ranked_q.size(), res);
            end
            for (l = 1; l <= int'(top_label); l++)
                label_hist[l] = '0;
            top_label = '0;
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failed = 1'b1;
        end
    endfunction

    // result side: random pop with one long hold on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
        begin
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_ranked_output
        rsr_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (ranked_q.size() == 0)
            begin
                $display("%0t: unexpected result, rank %0d label %0d count %0d last %0d",
                         $time, rank, region_label, voxel_count, last);
                failed = 1'b1;
            end
            else
            begin
                want = ranked_q.pop_front();
                check_field("rank", 32'(want.rank), 32'(rank));
                check_field("region_label", 32'(want.region_label), 32'(region_label));
                check_field("voxel_count", 32'(want.voxel_count), 32'(voxel_count));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // one item transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op_code, input logic [rsr_pkg::LABEL_W-1:0] lab);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        op <= op_code;
        label <= lab;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_item(op_code, lab);
        items_sent++;
    endtask

    // stop sending, let every result drain and the clearing pass finish
    task automatic drain_and_settle();
        push <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_count(input logic [rsr_pkg::TOP_W-1:0] value);
        drain_and_settle();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        emit_limit = value;
    endtask

    // a run of voxels over labels up to max_lab, closed by a finish
    task automatic send_region_set(input int n_vox, input int max_lab);
        int i;
        for (i = 0; i < n_vox; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(OP_VOXEL, '0);
            else
                send_item(OP_VOXEL, rsr_pkg::LABEL_W'($urandom_range(1, max_lab)));
        end
        send_item(OP_FINISH, rsr_pkg::LABEL_W'($urandom_range(0, 1023)));
    endtask

    // loose items, finishes dropped in at random
    task automatic send_noise(input int k);
        int i;
        for (i = 0; i < k; i++)
            send_item(($urandom_range(0, 3) == 0) ? OP_FINISH : OP_VOXEL,
                      rsr_pkg::LABEL_W'($urandom_range(0, 63)));
    endtask

    // reset value of top_count, ties, zero counts and background
    task automatic test_default_ranking();
        send_item(OP_VOXEL, 10'd0);
        send_item(OP_VOXEL, 10'd3);
        send_item(OP_VOXEL, 10'd3);
        send_item(OP_VOXEL, 10'd5);
        send_item(OP_VOXEL, 10'd1);
        send_item(OP_VOXEL, 10'd0);
        send_item(OP_FINISH, 10'd1023);
    endtask

    // finish with nothing counted, also after background only
    task automatic test_empty_volume();
        send_item(OP_FINISH, 10'd0);
        send_item(OP_VOXEL, 10'd0);
        send_item(OP_FINISH, 10'h155);
    endtask

    // top_count of one, zero, and above the emit limit with the highest label
    task automatic test_top_count_extremes();
        write_top_count(7'd1);
        send_item(OP_VOXEL, 10'd2);
        send_item(OP_VOXEL, 10'd2);
        send_item(OP_VOXEL, 10'd7);
        send_item(OP_FINISH, 10'd0);
        write_top_count(7'd0);
        send_item(OP_VOXEL, 10'd4);
        send_item(OP_FINISH, 10'd0);
        write_top_count(7'd127);
        send_item(OP_VOXEL, 10'd1023);
        send_item(OP_VOXEL, 10'd512);
        send_item(OP_FINISH, 10'd0);
    endtask

    // long result stall while items keep coming, so the input backs up
    task automatic test_output_stall();
        write_top_count(7'd64);
        hold_req = 1'b1;
        repeat (4) send_region_set($urandom_range(6, 12), $urandom_range(4, 12));
    endtask

    // random rankings over several top_count settings, one phase without idling
    task automatic test_random_rankings();
        int phase;
        int stop_at;
        int max_lab;
        bit big_used;
        logic [rsr_pkg::TOP_W-1:0] top_val;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: top_val = 7'd64;
                1: top_val = rsr_pkg::TOP_W'($urandom_range(2, 63));
                2: top_val = 7'd1;
                3: top_val = rsr_pkg::TOP_W'($urandom_range(65, 127));
                4: top_val = rsr_pkg::TOP_W'($urandom_range(2, 20));
                default: top_val = rsr_pkg::TOP_COUNT_RESET;
            endcase
            write_top_count(top_val);
            steady = (phase == 4);
            big_used = 1'b0;
            stop_at = items_sent + 50;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    send_noise($urandom_range(1, 5));
                end
                else
                begin
                    // at most one wide label range per phase keeps the scans short
                    if (!big_used && $urandom_range(0, 9) == 0)
                    begin
                        big_used = 1'b1;
                        max_lab = $urandom_range(64, 1023);
                    end
                    else
                    begin
                        max_lab = $urandom_range(1, 24);
                    end
                    send_region_set($urandom_range(1, 30), max_lab);
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int i;
        for (i = 0; i < rsr_pkg::MAX_LABELS; i++)
            label_hist[i] = '0;
        top_label = '0;
        emit_limit = rsr_pkg::TOP_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_default_ranking();
        test_empty_volume();
        test_top_count_extremes();
        test_output_stall();
        test_random_rankings();
        drain_and_settle();
        if (!failed)
            $display("region_size_ranker_test: PASS");
        else
            $display("region_size_ranker_test: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #16000000;
        $display("region_size_ranker_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rsr_pkg.sv
hw/rtl/rsr_ram.sv
hw/rtl/rsr_front.sv
hw/rtl/rsr_out_queue.sv
hw/rtl/rsr_back.sv
hw/rtl/region_size_ranker.sv
tb/region_size_ranker_test.sv
